>>> sv/best_fit_block_allocator_unit_defines.svh
// assertion macros for the best-fit block allocator
`ifndef BEST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BFBA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator check failed");

// antecedent implies consequent in the next cycle
`define BFBA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

>>> sv/bfba_pkg.sv
// shared constants and types for the best-fit block allocator
package bfba_pkg;

   localparam int MAX_BLOCKS = 16;
   localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int SIZE_W     = 32;
   localparam int NUM_W      = 5;
   localparam int STAT_W     = 2;
   localparam int RSP_W      = 40;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [STAT_W-1:0] ST_ALLOCATED     = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_ALLOCATED = 2'd1;
   localparam logic [STAT_W-1:0] ST_ADDED         = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL          = 2'd3;

   typedef struct packed {
      logic              vld;
      logic              found;
      logic [SIZE_W-1:0] best;
      logic [IDX_W-1:0]  idx;
      logic [SIZE_W-1:0] req;
   } cand_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [SIZE_W-1:0] data;
   } wr_type;

endpackage

>>> sv/bfba_cell.sv
// one table cell: holds a block size and refines the passing best-fit candidate
module bfba_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [bfba_pkg::IDX_W-1:0] my_idx,
   input  logic [bfba_pkg::CNT_W-1:0] count,
   input  bfba_pkg::wr_type           wr,
   input  bfba_pkg::cand_type         cand_prev,
   output bfba_pkg::cand_type         cand_next
);
   import bfba_pkg::*;

   logic [SIZE_W-1:0] size_ff;
   cand_type          cand_ff;
   cand_type          cand_in;
   logic              occupied;
   logic              take;

   assign occupied = CNT_W'(my_idx) < count;
   assign take     = occupied && (size_ff >= cand_prev.req) &&
                     (!cand_prev.found || (size_ff < cand_prev.best));

   always_comb begin
      cand_in = cand_prev;
      if (take) begin
         cand_in.found = 1'b1;
         cand_in.best  = size_ff;
         cand_in.idx   = my_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.idx == my_idx)) begin
         size_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.vld <= 1'b0;
      end else begin
         cand_ff.vld <= cand_in.vld;
      end
      cand_ff.found <= cand_in.found;
      cand_ff.best  <= cand_in.best;
      cand_ff.idx   <= cand_in.idx;
      cand_ff.req   <= cand_in.req;
   end

   assign cand_next = cand_ff;

endmodule

>>> sv/best_fit_block_allocator_unit.sv
// top level of the best-fit block allocator: control, result register and cell row
//
// channel | dir | beat contents
// req_    | in  | tdata: size[31:0]; tuser: cmd (0 add, 1 allocate)
// rsp_    | out | tdata: status[1:0], block_number[6:2], remaining[38:7], zero pad
//
// an add item writes its cell and loads the result register directly; an allocate item
// walks the candidate through the cell registers along the row, then writes back and loads it
// one item in flight at a time; the result register frees the input side
// as soon as its beat is taken
// synchronous reset empties the table and drops any pending result
module best_fit_block_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // size[31:0]
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[1:0], block_number[6:2], remaining[38:7]
);
   import bfba_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic              state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   cand_type          cand [0:MAX_BLOCKS];
   wr_type            wr;
   logic              accept;
   logic              tail_done;
   logic [SIZE_W-1:0] left;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_vld_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign tail_done  = (state_ff == ST_SCAN) && cand[MAX_BLOCKS].vld;
   assign left       = cand[MAX_BLOCKS].best - cand[MAX_BLOCKS].req;

   // head of the row
   always_comb begin
      cand[0].vld   = accept && (req_tuser == CMD_ALLOC);
      cand[0].found = 1'b0;
      cand[0].best  = '0;
      cand[0].idx   = '0;
      cand[0].req   = req_tdata;
   end

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      bfba_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .my_idx    (IDX_W'(i)),
         .count     (count_ff),
         .wr        (wr),
         .cand_prev (cand[i]),
         .cand_next (cand[i+1])
      );
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      wr.en       = 1'b0;
      wr.idx      = cand[MAX_BLOCKS].idx;
      wr.data     = left;
      if (accept && (req_tuser == CMD_ADD)) begin
         rsp_vld_in = 1'b1;
         if (count_ff < CNT_W'(MAX_BLOCKS)) begin
            wr.en       = 1'b1;
            wr.idx      = count_ff[IDX_W-1:0];
            wr.data     = req_tdata;
            count_in    = count_ff + CNT_W'(1);
            rsp_data_in = {1'b0, req_tdata, NUM_W'(count_ff) + NUM_W'(1), ST_ADDED};
         end else begin
            rsp_data_in = {1'b0, SIZE_W'(0), NUM_W'(0), ST_FULL};
         end
      end else if (accept) begin
         state_in = ST_SCAN;
      end
      if (tail_done) begin
         state_in   = ST_IDLE;
         rsp_vld_in = 1'b1;
         if (cand[MAX_BLOCKS].found) begin
            wr.en       = 1'b1;
            rsp_data_in = {1'b0, left, NUM_W'(cand[MAX_BLOCKS].idx) + NUM_W'(1),
                           ST_ALLOCATED};
         end else begin
            rsp_data_in = {1'b0, SIZE_W'(0), NUM_W'(0), ST_NOT_ALLOCATED};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sv/bfba_checker.sv
// port-level checks for the best-fit block allocator, bound to the top level
`include "best_fit_block_allocator_unit_defines.svh"

module bfba_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import bfba_pkg::*;

   logic [STAT_W-1:0] st;
   logic [NUM_W-1:0]  num;
   logic [SIZE_W-1:0] rem;
   logic              placed;
   logic              refused;

   assign st      = rsp_tdata[1:0];
   assign num     = rsp_tdata[6:2];
   assign rem     = rsp_tdata[38:7];
   assign placed  = rsp_tvalid && (st == ST_ALLOCATED || st == ST_ADDED);
   assign refused = rsp_tvalid && (st == ST_NOT_ALLOCATED || st == ST_FULL);

   // stalled result beat holds
   `BFBA_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // a placed block always carries a number
   `BFBA_ASSERT_IMP(a_num_set, placed, num != '0)
   // refusals carry neither number nor size
   `BFBA_ASSERT_IMP(a_refuse_zero, refused, num == '0 && rem == '0)
   // pad bit is always clear
   `BFBA_ASSERT_IMP(a_pad_zero, rsp_tvalid, rsp_tdata[39] == 1'b0)

endmodule

bind best_fit_block_allocator_unit bfba_checker u_bfba_checker (.*);

>>> test/best_fit_block_allocator_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the best-fit block allocator: directed table then random requests
module best_fit_block_allocator_unit_tb;
   import bfba_pkg::*;

   localparam int N_DIRECTED  = 25;
   localparam int N_RANDOM    = 1725;
   localparam int PAUSE_AT    = 900;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN       = 3 * (MAX_BLOCKS + 1);
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  number;
      logic [31:0] remaining;
   } alloc_outcome_type;

   typedef struct packed {
      logic              cmd;
      logic [31:0]       size;
      logic              fixed_exp;
      alloc_outcome_type want;
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   logic [31:0]       free_size [MAX_BLOCKS];
   int                table_count = 0;
   alloc_outcome_type pending_outcomes [$];
   int                mismatches  = 0;
   int                cycle_count = 0;
   int                status_seen [4] = '{0, 0, 0, 0};
   bit                sender_calm = 1'b0;
   bit                receiver_calm = 1'b0;

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{CMD_ALLOC, 32'd5,          1'b1, '{ST_NOT_ALLOCATED, 5'd0, 32'd0}},
      '{CMD_ADD,   32'd0,          1'b1, '{ST_ADDED, 5'd1, 32'd0}},
      '{CMD_ADD,   32'hFFFF_FFFF,  1'b1, '{ST_ADDED, 5'd2, 32'hFFFF_FFFF}},
      '{CMD_ALLOC, 32'd0,          1'b1, '{ST_ALLOCATED, 5'd1, 32'd0}},
      '{CMD_ALLOC, 32'hFFFF_FFFF,  1'b1, '{ST_ALLOCATED, 5'd2, 32'd0}},
      '{CMD_ALLOC, 32'd1,          1'b1, '{ST_NOT_ALLOCATED, 5'd0, 32'd0}},
      '{CMD_ADD,   32'd1000,       1'b0, '0},
      '{CMD_ADD,   32'd1000,       1'b0, '0},
      '{CMD_ADD,   32'd500,        1'b0, '0},
      '{CMD_ALLOC, 32'd600,        1'b0, '0},
      '{CMD_ALLOC, 32'd400,        1'b0, '0},
      '{CMD_ADD,   32'h8000_0000,  1'b0, '0},
      '{CMD_ADD,   32'h7FFF_FFFF,  1'b0, '0},
      '{CMD_ADD,   32'hFFFF_FFFF,  1'b0, '0},
      '{CMD_ADD,   32'd1,          1'b0, '0},
      '{CMD_ADD,   32'hAAAA_AAAA,  1'b0, '0},
      '{CMD_ADD,   32'h5555_5555,  1'b0, '0},
      '{CMD_ADD,   32'd2,          1'b0, '0},
      '{CMD_ADD,   32'd123456,     1'b0, '0},
      '{CMD_ADD,   32'hFFFF_0000,  1'b0, '0},
      '{CMD_ADD,   32'd1000,       1'b0, '0},
      '{CMD_ADD,   32'hC000_0000,  1'b0, '0},
      '{CMD_ADD,   32'd7,          1'b1, '{ST_FULL, 5'd0, 32'd0}},
      '{CMD_ALLOC, 32'h8000_0001,  1'b0, '0},
      '{CMD_ALLOC, 32'd0,          1'b0, '0}
   };

   best_fit_block_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic alloc_outcome_type best_fit_outcome(logic cmd, logic [31:0] size);
      alloc_outcome_type o;
      int pick;
      o = '{ST_NOT_ALLOCATED, 5'd0, 32'd0};
      pick = -1;
      if (cmd == CMD_ADD) begin
         if (table_count >= MAX_BLOCKS) begin
            o = '{ST_FULL, 5'd0, 32'd0};
         end else begin
            free_size[table_count] = size;
            table_count++;
            o = '{ST_ADDED, 5'(table_count), size};
         end
      end else begin
         for (int k = 0; k < table_count; k++) begin
            if (free_size[k] >= size && (pick < 0 || free_size[k] < free_size[pick])) begin
               pick = k;
            end
         end
         if (pick >= 0) begin
            free_size[pick] = free_size[pick] - size;
            o = '{ST_ALLOCATED, 5'(pick + 1), free_size[pick]};
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 40) begin
         $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      end
   endtask

   task automatic send_item(logic cmd, logic [31:0] size, logic fixed_exp,
                            alloc_outcome_type want);
      int gap;
      alloc_outcome_type predicted;
      gap = sender_calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= size;
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = best_fit_outcome(cmd, size);
      pending_outcomes.push_back(fixed_exp ? want : predicted);
   endtask

   // result beat check
   always @(posedge clock) begin
      alloc_outcome_type got, want;
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = '{rsp_tdata[1:0], rsp_tdata[6:2], rsp_tdata[38:7]};
         status_seen[got.status]++;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected beat, status", 32'(got.status), 32'd0);
         end else begin
            want = pending_outcomes.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.number !== want.number)
               report_mismatch("block_number", 32'(got.number), 32'(want.number));
            if (got.remaining !== want.remaining)
               report_mismatch("remaining", got.remaining, want.remaining);
         end
      end
   end

   // result side: random stalls and one long hold-off
   initial begin
      int stall;
      int taken;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 49) == 0) receiver_calm = !receiver_calm;
         stall = receiver_calm ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         taken++;
         if (taken == HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles with %0d beats outstanding", cycle_count,
               pending_outcomes.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int kind, k;
      logic [31:0] b, top, size;
      logic cmd;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].cmd, directed_rows[i].size, directed_rows[i].fixed_exp,
                   directed_rows[i].want);
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == PAUSE_AT) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_outcomes.size() != 0);
         end
         if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
         k = $urandom_range(0, table_count - 1);
         b = free_size[k];
         top = '0;
         for (int j = 0; j < table_count; j++) begin
            if (free_size[j] > top) top = free_size[j];
         end
         cmd  = CMD_ALLOC;
         kind = $urandom_range(0, 99);
         if (kind < 4) begin
            cmd  = CMD_ADD;
            size = $urandom;
         end else if (kind < 45) begin
            size = $urandom & ((32'd1 << $urandom_range(0, 16)) - 32'd1);
         end else if (kind < 72) begin
            size = b >> $urandom_range(1, 12);
         end else if (kind < 77) begin
            size = b - $urandom_range(0, (b < 32'd255) ? b : 32'd255);
         end else if (kind < 79) begin
            size = b;
         end else if (kind < 90) begin
            size = (top == 32'hFFFF_FFFF) ? $urandom : $urandom_range(top + 1, 32'hFFFF_FFFF);
         end else begin
            size = $urandom;
         end
         send_item(cmd, size, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("%0d items: %0d allocated, %0d refused, %0d blocks added, %0d table full",
               N_DIRECTED + N_RANDOM, status_seen[ST_ALLOCATED], status_seen[ST_NOT_ALLOCATED],
               status_seen[ST_ADDED], status_seen[ST_FULL]);
      $display("size extremes, ties, zero requests, oversize requests, %0d-cycle result stall",
               HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/bfba_pkg.sv
sv/bfba_cell.sv
sv/best_fit_block_allocator_unit.sv
sv/bfba_checker.sv
test/best_fit_block_allocator_unit_tb.sv
